[rtl/core/html_text_extractor_assert.svh]
// assertion macros shared by the html text extractor rtl
`ifndef HTML_TEXT_EXTRACTOR_ASSERT_SVH
`define HTML_TEXT_EXTRACTOR_ASSERT_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge out of reset
`define HTE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// antecedent at one edge implies consequent at the next
`define HTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define HTE_ASSERT_ALWAYS(label, cond, msg)
`define HTE_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[rtl/core/hte_pkg.sv]
// types, constants and head-decision functions of the html text extractor
`timescale 1ns / 1ps
`default_nettype none

package hte_pkg;

  localparam int unsigned WinDepth = 9;

  typedef logic [WinDepth-1:0][7:0] win_t;
  typedef logic [3:0] cnt_t;
  typedef logic [4:0] run_t;

  typedef struct packed {
    win_t win;
    cnt_t fill;
    cnt_t skip;
    logic in_tag;
    logic in_script;
    run_t run;
  } st_t;

  typedef struct packed {
    st_t        st;
    logic       emit;
    logic [7:0] ch;
  } dec_t;

  localparam cnt_t FillFull = cnt_t'(WinDepth);
  localparam run_t RunMax   = 5'd31;
  localparam logic [3:0] LimitReset = 4'd2;

  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChLf    = 8'h0A;

  // patterns stored with the first byte at entry 0
  localparam win_t PatScriptOpen =
    {8'h00, 8'h00, 8'h74, 8'h70, 8'h69, 8'h72, 8'h63, 8'h73, 8'h3C};
  localparam win_t PatScriptClose =
    {8'h3E, 8'h74, 8'h70, 8'h69, 8'h72, 8'h63, 8'h73, 8'h2F, 8'h3C};
  localparam win_t PatLt =
    {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h3B, 8'h74, 8'h6C, 8'h26};
  localparam win_t PatGt =
    {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h3B, 8'h74, 8'h67, 8'h26};
  localparam win_t PatAmp =
    {8'h00, 8'h00, 8'h00, 8'h00, 8'h3B, 8'h70, 8'h6D, 8'h61, 8'h26};
  localparam win_t PatNbsp =
    {8'h00, 8'h00, 8'h00, 8'h3B, 8'h70, 8'h73, 8'h62, 8'h6E, 8'h26};

  localparam cnt_t LenScriptOpen  = 4'd7;
  localparam cnt_t LenScriptClose = 4'd9;
  localparam cnt_t LenLt          = 4'd4;
  localparam cnt_t LenGt          = 4'd4;
  localparam cnt_t LenAmp         = 4'd5;
  localparam cnt_t LenNbsp        = 4'd6;

  function automatic logic head_match(win_t w, cnt_t fill, win_t pat, cnt_t len, logic fold);
    logic       ok;
    logic [7:0] c;
    ok = (fill >= len);
    for (int k = 0; k < WinDepth; k++) begin
      c = w[k];
      if (fold && c >= 8'h41 && c <= 8'h5A) c = c + 8'd32;
      if ((cnt_t'(k) < len) && (c != pat[k])) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic st_t drop_head(st_t s);
    st_t r;
    r = s;
    for (int k = 0; k < WinDepth - 1; k++) r.win[k] = s.win[k+1];
    r.fill = s.fill - 4'd1;
    return r;
  endfunction

  function automatic st_t push_byte(st_t s, logic [7:0] b);
    st_t r;
    r = s;
    if (s.fill < FillFull) begin
      for (int k = 0; k < WinDepth; k++) begin
        if (cnt_t'(k) == s.fill) r.win[k] = b;
      end
      r.fill = s.fill + 4'd1;
    end
    return r;
  endfunction

  // settle the head byte: one word out at most
  function automatic dec_t decide(st_t s, logic [3:0] limit);
    dec_t       r;
    st_t        t;
    logic [7:0] c;
    logic [7:0] ch;
    logic       emit;
    cnt_t       used;
    run_t       run_inc;
    r.st   = s;
    r.emit = 1'b0;
    r.ch   = 8'h00;
    if (s.fill != 4'd0) begin
      if (s.skip != 4'd0) begin
        r.st      = drop_head(s);
        r.st.skip = s.skip - 4'd1;
      end else begin
        c    = s.win[0];
        ch   = c;
        emit = 1'b0;
        used = 4'd1;
        if (head_match(s.win, s.fill, PatScriptOpen, LenScriptOpen, 1'b1)) r.st.in_script = 1'b1;
        if (head_match(s.win, s.fill, PatScriptClose, LenScriptClose, 1'b1)) begin
          r.st.in_script = 1'b0;
          used = LenScriptClose;
        end else if (r.st.in_script) begin
          // suppressed script body
        end else if (c == ChLt) begin
          r.st.in_tag = 1'b1;
        end else if (c == ChGt) begin
          r.st.in_tag = 1'b0;
          emit = 1'b1;
          ch   = ChLf;
        end else if (s.in_tag) begin
          // tag byte dropped
        end else if (c == ChAmp) begin
          emit = 1'b1;
          if (head_match(s.win, s.fill, PatLt, LenLt, 1'b0)) begin
            ch = ChLt;
            used = LenLt;
          end else if (head_match(s.win, s.fill, PatGt, LenGt, 1'b0)) begin
            ch = ChGt;
            used = LenGt;
          end else if (head_match(s.win, s.fill, PatAmp, LenAmp, 1'b0)) begin
            ch = ChAmp;
            used = LenAmp;
          end else if (head_match(s.win, s.fill, PatNbsp, LenNbsp, 1'b0)) begin
            ch = ChSpace;
            used = LenNbsp;
          end
        end else begin
          emit = 1'b1;
        end
        if (emit) begin
          r.ch = ch;
          if (ch == ChLf) begin
            run_inc   = (s.run == RunMax) ? s.run : s.run + 5'd1;
            r.st.run  = run_inc;
            r.emit    = (run_inc <= {1'b0, limit});
          end else begin
            r.st.run = 5'd0;
            r.emit   = 1'b1;
          end
        end
        t         = drop_head(r.st);
        t.skip    = used - 4'd1;
        r.st      = t;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/html_text_extractor.sv]
// html text extractor: 9-byte lookahead tag stripper and entity decoder
// throughput: one input word per cycle while the output side keeps up and no drain runs
// latency: a head decided at an accepting edge is registered there, valid the next cycle
// a head byte is decided once 9 bytes are held; after the last word, input stalls while
// each held byte is settled, one head per cycle while the output keeps up, then the marker
// reset (rst_n low, synchronous): stream state cleared, run limit back to 2
`timescale 1ns / 1ps
`default_nettype none

module html_text_extractor (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_char,
  output logic            out_char_present,
  output logic            out_last,
  input  wire logic       cfg_wr_en,
  input  wire logic [3:0] cfg_wr_data
);

`include "html_text_extractor_assert.svh"

  hte_pkg::win_t win_r, win_nxt;
  hte_pkg::cnt_t fill_r, fill_nxt;
  hte_pkg::cnt_t skip_r, skip_nxt;
  logic          tag_r, tag_nxt;
  logic          script_r, script_nxt;
  hte_pkg::run_t run_r, run_nxt;
  logic          drain_r, drain_nxt;
  logic [3:0]    limit_r, limit_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_char_r, out_char_nxt;
  logic          out_present_r, out_present_nxt;
  logic          out_last_r, out_last_nxt;

  hte_pkg::st_t  cur;
  hte_pkg::st_t  pushed;
  hte_pkg::st_t  st_nxt;
  hte_pkg::dec_t dec_first;
  hte_pkg::dec_t dec_second;
  hte_pkg::dec_t dec_drain;
  logic          out_free;
  logic          in_acc;
  logic          load;
  logic [7:0]    load_char;
  logic          load_present;
  logic          load_last;

  always_comb begin
    cur.win       = win_r;
    cur.fill      = fill_r;
    cur.skip      = skip_r;
    cur.in_tag    = tag_r;
    cur.in_script = script_r;
    cur.run       = run_r;

    out_free = !out_valid_r || !out_stall;
    in_stall = drain_r || !out_free;
    in_acc   = in_valid && !in_stall;

    // head decided before the push only when the window is full
    if (fill_r >= hte_pkg::FillFull) begin
      dec_first = hte_pkg::decide(cur, limit_r);
    end else begin
      dec_first.st   = cur;
      dec_first.emit = 1'b0;
      dec_first.ch   = 8'h00;
    end
    pushed = hte_pkg::push_byte(dec_first.st, in_byte);
    if (!dec_first.emit && pushed.fill >= hte_pkg::FillFull) begin
      dec_second = hte_pkg::decide(pushed, limit_r);
    end else begin
      dec_second.st   = pushed;
      dec_second.emit = 1'b0;
      dec_second.ch   = 8'h00;
    end
    dec_drain = hte_pkg::decide(cur, limit_r);

    st_nxt       = cur;
    drain_nxt    = drain_r;
    load         = 1'b0;
    load_char    = 8'h00;
    load_present = 1'b1;
    load_last    = 1'b0;
    if (in_acc) begin
      if (in_last) begin
        st_nxt    = pushed;
        drain_nxt = 1'b1;
        load      = dec_first.emit;
        load_char = dec_first.ch;
      end else begin
        st_nxt    = dec_second.st;
        load      = dec_first.emit || dec_second.emit;
        load_char = dec_first.emit ? dec_first.ch : dec_second.ch;
      end
    end else if (drain_r && out_free) begin
      if (fill_r != 4'd0) begin
        st_nxt    = dec_drain.st;
        load      = dec_drain.emit;
        load_char = dec_drain.ch;
      end else begin
        // end marker, stream starts over
        load          = 1'b1;
        load_present  = 1'b0;
        load_last     = 1'b1;
        st_nxt.fill      = 4'd0;
        st_nxt.skip      = 4'd0;
        st_nxt.in_tag    = 1'b0;
        st_nxt.in_script = 1'b0;
        st_nxt.run       = 5'd0;
        drain_nxt        = 1'b0;
      end
    end

    win_nxt    = st_nxt.win;
    fill_nxt   = st_nxt.fill;
    skip_nxt   = st_nxt.skip;
    tag_nxt    = st_nxt.in_tag;
    script_nxt = st_nxt.in_script;
    run_nxt    = st_nxt.run;

    limit_nxt = cfg_wr_en ? cfg_wr_data : limit_r;

    out_valid_nxt   = out_valid_r;
    out_char_nxt    = out_char_r;
    out_present_nxt = out_present_r;
    out_last_nxt    = out_last_r;
    if (out_free) begin
      out_valid_nxt   = load;
      out_char_nxt    = load_char;
      out_present_nxt = load_present;
      out_last_nxt    = load_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= 4'd0;
      skip_r      <= 4'd0;
      tag_r       <= 1'b0;
      script_r    <= 1'b0;
      run_r       <= 5'd0;
      drain_r     <= 1'b0;
      limit_r     <= hte_pkg::LimitReset;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      skip_r      <= skip_nxt;
      tag_r       <= tag_nxt;
      script_r    <= script_nxt;
      run_r       <= run_nxt;
      drain_r     <= drain_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r         <= win_nxt;
    out_char_r    <= out_char_nxt;
    out_present_r <= out_present_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_char         = out_char_r;
  assign out_char_present = out_present_r;
  assign out_last         = out_last_r;

  `HTE_ASSERT_ALWAYS(a_fill_bound, fill_r <= hte_pkg::FillFull, "window fill beyond depth")
  `HTE_ASSERT_ALWAYS(a_skip_bound, skip_r <= fill_r, "skip count exceeds held bytes")
  `HTE_ASSERT_ALWAYS(a_drain_stall, !drain_r || in_stall, "input taken while draining")
  `HTE_ASSERT_NEXT(a_fill_idle, !drain_r && !in_acc, $stable(fill_r), "window moved with no word")
  `HTE_ASSERT_ALWAYS(a_marker_form, !(out_valid_r && out_last_r) || !out_present_r,
                     "end marker carries a char")

endmodule

`default_nettype wire
